### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sensor alarm block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

### rtl/esafr_pkg.sv
// ----------------------------------------------------------------------------
// esafr_pkg
// Types and constants shared by the sensor alarm and fan ramp modules.
// ----------------------------------------------------------------------------
package esafr_pkg;

	// Field widths.
	localparam int TEMP_W    = 8;
	localparam int HUM_W     = 8;
	localparam int RAW_W     = 12;
	localparam int SMOG_W    = 13;
	localparam int PCT_W     = 7;
	localparam int PROD_W    = 28;
	localparam int LIGHT_Y_W = 9;
	localparam int FAN_NUM_W = 15;
	localparam int DIV_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;

	// Smog conversion: (s * 33000 - 16384000) >> 14, floored at zero.
	localparam logic [PROD_W-1:0] SMOG_GAIN   = 28'd33000;
	localparam logic [PROD_W-1:0] SMOG_OFFSET = 28'd16384000;

	// Light conversion: (1500 - l) / 12 computed as ((1500 - l) >> 2) * 171 >> 9.
	localparam logic [RAW_W-1:0] LIGHT_FULL = 12'd1500;
	localparam logic [7:0]       RECIP3     = 8'd171;

	localparam logic [PCT_W-1:0]     FAN_FULL_PCT = 7'd100;
	localparam logic [FAN_NUM_W-1:0] PCT_SCALE    = 15'd100;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOG_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAN_FULL   = 3'd4;

	// Register reset values.
	localparam logic [TEMP_W-1:0] RST_TEMP_LIMIT = 8'd25;
	localparam logic [HUM_W-1:0]  RST_HUM_LIMIT  = 8'd90;
	localparam logic [SMOG_W-1:0] RST_SMOG_LIMIT = 13'd3000;
	localparam logic [TEMP_W-1:0] RST_FAN_START  = 8'd18;
	localparam logic [TEMP_W-1:0] RST_FAN_FULL   = 8'd30;

	// Depth of the queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FAN_ZERO,
		FAN_FULL,
		FAN_RAMP
	} fan_mode_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp_limit;
		logic [HUM_W-1:0]  humidity_limit;
		logic [SMOG_W-1:0] smog_limit;
		logic [TEMP_W-1:0] fan_start_temp;
		logic [TEMP_W-1:0] fan_full_temp;
	} cfg_t;

	// One classified request as it travels from the front to the back end.
	typedef struct packed {
		logic [SMOG_W-1:0]    smog_level;
		logic [PCT_W-1:0]     light_percent;
		logic                 temp_hit;
		logic                 humidity_hit;
		logic                 smog_hit;
		fan_mode_t            fan_mode;
		logic [FAN_NUM_W-1:0] fan_num;
		logic [TEMP_W-1:0]    fan_den;
	} entry_t;

endpackage

### rtl/esafr_front.sv
// ----------------------------------------------------------------------------
// esafr_front
// Accepts sensor readings, converts the ADC samples and classifies the fan case.
// ----------------------------------------------------------------------------
module esafr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [esafr_pkg::TEMP_W-1:0]   temp_int,
	input  logic [esafr_pkg::HUM_W-1:0]    humidity_int,
	input  logic                           adc_valid,
	input  logic [esafr_pkg::RAW_W-1:0]    smog_raw,
	input  logic [esafr_pkg::RAW_W-1:0]    light_raw,
	input  esafr_pkg::cfg_t                cfg,
	input  logic                           q_full,
	output logic                           q_push,
	output esafr_pkg::entry_t              q_data
);

	logic [esafr_pkg::RAW_W-1:0]     smog_s;
	logic [esafr_pkg::RAW_W-1:0]     light_l;
	logic [esafr_pkg::RAW_W-1:0]     light_diff;
	logic [esafr_pkg::PROD_W-1:0]    smog_prod;
	logic [esafr_pkg::LIGHT_Y_W-1:0] light_y;
	esafr_pkg::fan_mode_t            fan_mode;
	logic                            accept;

	logic                            valid_s1;
	logic [esafr_pkg::PROD_W-1:0]    smog_prod_s1;
	logic [esafr_pkg::LIGHT_Y_W-1:0] light_y_s1;
	logic                            temp_hit_s1;
	logic                            humidity_hit_s1;
	esafr_pkg::fan_mode_t            fan_mode_s1;
	logic [esafr_pkg::TEMP_W-1:0]    fan_diff_s1;
	logic [esafr_pkg::TEMP_W-1:0]    fan_den_s1;

	logic [esafr_pkg::PROD_W-1:0]    smog_excess;
	logic [16:0]                     light_prod;

	// Samples that are not valid read as zero.
	assign smog_s     = adc_valid ? smog_raw : '0;
	assign light_l    = adc_valid ? light_raw : '0;
	assign smog_prod  = esafr_pkg::PROD_W'(smog_s) * esafr_pkg::SMOG_GAIN;
	assign light_diff = esafr_pkg::LIGHT_FULL - light_l;
	assign light_y    = (light_l >= esafr_pkg::LIGHT_FULL) ? '0 : light_diff[10:2];

	always_comb begin
		if (temp_int > cfg.fan_full_temp) begin
			fan_mode = esafr_pkg::FAN_FULL;
		end else if (temp_int < cfg.fan_start_temp) begin
			fan_mode = esafr_pkg::FAN_ZERO;
		end else if (cfg.fan_full_temp <= cfg.fan_start_temp) begin
			fan_mode = esafr_pkg::FAN_FULL;
		end else begin
			fan_mode = esafr_pkg::FAN_RAMP;
		end
	end

	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smog_prod_s1    <= smog_prod;
			light_y_s1      <= light_y;
			temp_hit_s1     <= temp_int > cfg.temp_limit;
			humidity_hit_s1 <= humidity_int > cfg.humidity_limit;
			fan_mode_s1     <= fan_mode;
			fan_diff_s1     <= temp_int - cfg.fan_start_temp;
			fan_den_s1      <= cfg.fan_full_temp - cfg.fan_start_temp;
		end
	end

	// The excess is only used when the product is above the offset.
	assign smog_excess = smog_prod_s1 - esafr_pkg::SMOG_OFFSET;
	assign light_prod  = 17'(light_y_s1) * 17'(esafr_pkg::RECIP3);

	always_comb begin
		q_data               = '0;
		q_data.smog_level    = (smog_prod_s1 > esafr_pkg::SMOG_OFFSET) ?
			smog_excess[26:14] : '0;
		q_data.light_percent = light_prod[15:9];
		q_data.temp_hit      = temp_hit_s1;
		q_data.humidity_hit  = humidity_hit_s1;
		q_data.smog_hit      = q_data.smog_level > cfg.smog_limit;
		q_data.fan_mode      = fan_mode_s1;
		q_data.fan_num       = esafr_pkg::FAN_NUM_W'(fan_diff_s1) * esafr_pkg::PCT_SCALE;
		q_data.fan_den       = fan_den_s1;
	end

endmodule

### rtl/esafr_queue.sv
// ----------------------------------------------------------------------------
// esafr_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module esafr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  esafr_pkg::entry_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output esafr_pkg::entry_t rd_data,
	output logic              empty
);

	esafr_pkg::entry_t                slot_q [esafr_pkg::QUEUE_DEPTH];
	logic [esafr_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [esafr_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [esafr_pkg::QCNT_W-1:0]     count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full    = count_q == esafr_pkg::QCNT_W'(esafr_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == esafr_pkg::QPTR_W'(esafr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == esafr_pkg::QPTR_W'(esafr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/esafr_back.sv
// ----------------------------------------------------------------------------
// esafr_back
// Runs the fan ramp divide, updates the alarm flags and holds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esafr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  esafr_pkg::entry_t             q_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [esafr_pkg::SMOG_W-1:0]  smog_level,
	output logic [esafr_pkg::PCT_W-1:0]   light_percent,
	output logic                          temp_alarm,
	output logic                          humidity_alarm,
	output logic                          smog_alarm,
	output logic                          alarm_drive,
	output logic                          alarm_raised,
	output logic [esafr_pkg::PCT_W-1:0]   fan_speed
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_FIN
	} state_t;

	state_t                             st_q;
	esafr_pkg::entry_t                  ent_q;
	logic [esafr_pkg::TEMP_W-1:0]       rem_q;
	logic [esafr_pkg::DIV_W-1:0]        div_q;
	logic [2:0]                         step_q;
	logic                               temp_flag_q;
	logic                               humidity_flag_q;
	logic                               smog_flag_q;

	logic                               out_valid_q;
	logic [esafr_pkg::SMOG_W-1:0]       smog_level_q;
	logic [esafr_pkg::PCT_W-1:0]        light_percent_q;
	logic                               temp_alarm_q;
	logic                               humidity_alarm_q;
	logic                               smog_alarm_q;
	logic                               alarm_drive_q;
	logic                               alarm_raised_q;
	logic [esafr_pkg::PCT_W-1:0]        fan_speed_q;

	logic                               out_free;
	logic                               out_load;
	logic [esafr_pkg::TEMP_W:0]         part_a;
	logic [esafr_pkg::TEMP_W:0]         part_b;
	logic [esafr_pkg::TEMP_W-1:0]       rem_a;
	logic [esafr_pkg::TEMP_W-1:0]       rem_b;
	logic                               bit_a;
	logic                               bit_b;
	logic [esafr_pkg::PCT_W-1:0]        fan_value;

	assign out_free = ~out_valid_q | pop;
	assign out_load = (st_q == B_FIN) & out_free;
	assign q_pop    = (st_q == B_IDLE) & ~q_empty;

	// Two restoring divide steps per cycle; the quotient shifts in from the right.
	always_comb begin
		part_a = {rem_q, div_q[esafr_pkg::DIV_W-1]};
		bit_a  = part_a >= {1'b0, ent_q.fan_den};
		rem_a  = bit_a ? esafr_pkg::TEMP_W'(part_a - {1'b0, ent_q.fan_den}) :
			part_a[esafr_pkg::TEMP_W-1:0];
		part_b = {rem_a, div_q[esafr_pkg::DIV_W-2]};
		bit_b  = part_b >= {1'b0, ent_q.fan_den};
		rem_b  = bit_b ? esafr_pkg::TEMP_W'(part_b - {1'b0, ent_q.fan_den}) :
			part_b[esafr_pkg::TEMP_W-1:0];
	end

	always_comb begin
		unique case (ent_q.fan_mode)
			esafr_pkg::FAN_ZERO: fan_value = '0;
			esafr_pkg::FAN_FULL: fan_value = esafr_pkg::FAN_FULL_PCT;
			esafr_pkg::FAN_RAMP: fan_value = div_q[esafr_pkg::PCT_W-1:0];
			default:             fan_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q             <= B_IDLE;
			ent_q            <= '0;
			rem_q            <= '0;
			div_q            <= '0;
			step_q           <= '0;
			temp_flag_q      <= 1'b0;
			humidity_flag_q  <= 1'b0;
			smog_flag_q      <= 1'b0;
			out_valid_q      <= 1'b0;
			smog_level_q     <= '0;
			light_percent_q  <= '0;
			temp_alarm_q     <= 1'b0;
			humidity_alarm_q <= 1'b0;
			smog_alarm_q     <= 1'b0;
			alarm_drive_q    <= 1'b0;
			alarm_raised_q   <= 1'b0;
			fan_speed_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						ent_q  <= q_data;
						rem_q  <= '0;
						div_q  <= esafr_pkg::DIV_W'(q_data.fan_num);
						step_q <= '0;
						st_q   <= (q_data.fan_mode == esafr_pkg::FAN_RAMP) ? B_DIV : B_FIN;
					end
				end
				B_DIV: begin
					rem_q  <= rem_b;
					div_q  <= {div_q[esafr_pkg::DIV_W-3:0], bit_a, bit_b};
					step_q <= step_q + 1'b1;
					if (step_q == 3'(esafr_pkg::DIV_W / 2 - 1)) begin
						st_q <= B_FIN;
					end
				end
				B_FIN: begin
					if (out_free) begin
						smog_level_q     <= ent_q.smog_level;
						light_percent_q  <= ent_q.light_percent;
						temp_alarm_q     <= ent_q.temp_hit;
						humidity_alarm_q <= ent_q.humidity_hit;
						smog_alarm_q     <= ent_q.smog_hit;
						alarm_drive_q    <= ent_q.temp_hit | ent_q.humidity_hit |
							ent_q.smog_hit;
						alarm_raised_q   <= (ent_q.temp_hit & ~temp_flag_q) |
							(ent_q.humidity_hit & ~humidity_flag_q) |
							(ent_q.smog_hit & ~smog_flag_q);
						fan_speed_q      <= fan_value;
						temp_flag_q      <= ent_q.temp_hit;
						humidity_flag_q  <= ent_q.humidity_hit;
						smog_flag_q      <= ent_q.smog_hit;
						st_q             <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	assign empty          = ~out_valid_q;
	assign smog_level     = smog_level_q;
	assign light_percent  = light_percent_q;
	assign temp_alarm     = temp_alarm_q;
	assign humidity_alarm = humidity_alarm_q;
	assign smog_alarm     = smog_alarm_q;
	assign alarm_drive    = alarm_drive_q;
	assign alarm_raised   = alarm_raised_q;
	assign fan_speed      = fan_speed_q;

	`ASSERT_IMPLIES(a_raised_needs_drive, clk, arst_n, out_valid_q && alarm_raised_q, alarm_drive_q)
	`ASSERT_IMPLIES(a_fan_in_range, clk, arst_n, out_valid_q, fan_speed_q <= esafr_pkg::FAN_FULL_PCT)
	`ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, q_pop, st_q != B_IDLE)
	`ASSERT_NEXT(a_flags_track_result, clk, arst_n, out_load, (temp_flag_q == temp_alarm_q) && (humidity_flag_q == humidity_alarm_q) && (smog_flag_q == smog_alarm_q))

endmodule

### rtl/env_sensor_alarm_fan_ramp.sv
// ----------------------------------------------------------------------------
// env_sensor_alarm_fan_ramp
// Sensor alarm flags, smog and light conversion, and a temperature fan ramp.
// ----------------------------------------------------------------------------
// Flow: an accepted request is registered in the front-end stage, waits in the
// queue, is taken into the back end and is written to the result register. A
// ramp request first runs the radix-4 divider, which makes 2 quotient bits a cycle;
// the back end finishes one request before it takes the next.
// Reset: arst_n clears the alarm flags, the front stage, the queue and the limits to their defaults.
// ----------------------------------------------------------------------------
module env_sensor_alarm_fan_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input request channel.
	input  logic                                push,
	output logic                                full,
	input  logic [esafr_pkg::TEMP_W-1:0]        temp_int,
	input  logic [esafr_pkg::HUM_W-1:0]         humidity_int,
	input  logic                                adc_valid,
	input  logic [esafr_pkg::RAW_W-1:0]         smog_raw,
	input  logic [esafr_pkg::RAW_W-1:0]         light_raw,
	// Result channel.
	output logic                                empty,
	input  logic                                pop,
	output logic [esafr_pkg::SMOG_W-1:0]        smog_level,
	output logic [esafr_pkg::PCT_W-1:0]         light_percent,
	output logic                                temp_alarm,
	output logic                                humidity_alarm,
	output logic                                smog_alarm,
	output logic                                alarm_drive,
	output logic                                alarm_raised,
	output logic [esafr_pkg::PCT_W-1:0]         fan_speed,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [esafr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [esafr_pkg::CFG_DAT_W-1:0]     cfg_data
);

	esafr_pkg::cfg_t   cfg_q;
	esafr_pkg::entry_t fq_wr_data;
	esafr_pkg::entry_t fq_rd_data;
	logic              fq_wr_en;
	logic              fq_full;
	logic              fq_rd_en;
	logic              fq_empty;

	// The temperature, humidity and fan registers keep only the low 8 bits of the
	// written data; the smog limit keeps all 13. Indexes past the last register are accepted and ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_limit     <= esafr_pkg::RST_TEMP_LIMIT;
			cfg_q.humidity_limit <= esafr_pkg::RST_HUM_LIMIT;
			cfg_q.smog_limit     <= esafr_pkg::RST_SMOG_LIMIT;
			cfg_q.fan_start_temp <= esafr_pkg::RST_FAN_START;
			cfg_q.fan_full_temp  <= esafr_pkg::RST_FAN_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esafr_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit     <= cfg_data[7:0];
				esafr_pkg::REG_HUM_LIMIT:  cfg_q.humidity_limit <= cfg_data[7:0];
				esafr_pkg::REG_SMOG_LIMIT: cfg_q.smog_limit     <= cfg_data;
				esafr_pkg::REG_FAN_START:  cfg_q.fan_start_temp <= cfg_data[7:0];
				esafr_pkg::REG_FAN_FULL:   cfg_q.fan_full_temp  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The front end converts both ADC samples, compares temperature, humidity
	// and smog against their limits, and decides whether the fan speed is zero,
	// full or on the ramp. It holds one request in its own stage.
	esafr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.temp_int     (temp_int),
		.humidity_int (humidity_int),
		.adc_valid    (adc_valid),
		.smog_raw     (smog_raw),
		.light_raw    (light_raw),
		.cfg          (cfg_q),
		.q_full       (fq_full),
		.q_push       (fq_wr_en),
		.q_data       (fq_wr_data)
	);

	// Classified requests wait here while the back end runs a ramp divide, so
	// the front end keeps taking readings.
	esafr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_wr_en),
		.wr_data (fq_wr_data),
		.full    (fq_full),
		.rd_en   (fq_rd_en),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	// The back end owns the alarm flags, so the rising-edge pulse follows the
	// order in which requests were accepted. The result register lets it start
	// the next request while a finished result waits to be popped.
	esafr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (fq_empty),
		.q_pop          (fq_rd_en),
		.q_data         (fq_rd_data),
		.empty          (empty),
		.pop            (pop),
		.smog_level     (smog_level),
		.light_percent  (light_percent),
		.temp_alarm     (temp_alarm),
		.humidity_alarm (humidity_alarm),
		.smog_alarm     (smog_alarm),
		.alarm_drive    (alarm_drive),
		.alarm_raised   (alarm_raised),
		.fan_speed      (fan_speed)
	);

endmodule
